[sv/adaptive_context_frequency_model_core_defines.svh]
// assertion macros for the adaptive context frequency model core
`ifndef ADAPTIVE_CONTEXT_FREQUENCY_MODEL_CORE_DEFINES_SVH
`define ADAPTIVE_CONTEXT_FREQUENCY_MODEL_CORE_DEFINES_SVH

// condition holds in the same cycle
`define ACFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("acfm: same-cycle check failed");

// condition holds in the following cycle
`define ACFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("acfm: next-cycle check failed");

`endif

[sv/acfm_pkg.sv]
// shared constants and word types of the adaptive context frequency model
package acfm_pkg;

    // table shape
    localparam int SYMBOLS  = 256;
    localparam int CONTEXTS = 16;

    // fixed field widths
    localparam int FIELD_W = 21;
    localparam int SYM_W   = 8;
    localparam int CTX_W   = 4;
    localparam int CMD_W   = 2;

    // derived widths
    localparam int IDX_W  = $clog2(SYMBOLS);
    localparam int CIDX_W = $clog2(CONTEXTS);
    localparam int ADDR_W = CIDX_W + IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int RUN_W  = FIELD_W + IDX_W;

    localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(1 << 20);

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CTX_W-1:0]   context_id;
        logic [SYM_W-1:0]   symbol_in;
        logic [FIELD_W-1:0] target;
    } in_word_t;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol_out;
        logic [FIELD_W-1:0] cum_low;
        logic [FIELD_W-1:0] freq;
        logic [FIELD_W-1:0] total;
        logic               not_found;
    } out_word_t;

endpackage

[sv/acfm_ram.sv]
// generic simple dual-port ram with registered read
module acfm_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/adaptive_context_frequency_model_core.sv]
// top level of the adaptive context frequency model: per-context symbol counts
// Per-context symbol frequency table for an arithmetic coder. The counts sit in
// one ram of CONTEXTS x SYMBOLS words read one word per cycle, the context
// totals in flops. One word is worked on at a time. An encode lookup walks the
// counts of its context up to its symbol, a decode lookup up to the found
// symbol, and an update reads and writes one count, or also walks the whole
// context when it halves it; each walk reads one entry per cycle through the
// count ram's single read port. After reset a clearing pass writes every one
// of the 4096 counts to one, during which s_ready stays low; the rescale limit
// can be written at any time the block is idle. A finished result waits in an
// output register, so the next input word is taken while it is still unread.
`include "adaptive_context_frequency_model_core_defines.svh"

module adaptive_context_frequency_model_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  acfm_pkg::in_word_t            s_data,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output acfm_pkg::out_word_t           m_data,
    // rescale limit register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [acfm_pkg::FIELD_W-1:0]  cfg_wdata
);

    localparam int FW  = acfm_pkg::FIELD_W;
    localparam int IW  = acfm_pkg::IDX_W;
    localparam int CW  = acfm_pkg::CIDX_W;
    localparam int AW  = acfm_pkg::ADDR_W;
    localparam int RW  = acfm_pkg::RUN_W;
    localparam int SW  = acfm_pkg::SYM_W;

    acfm_pkg::state_t     st_reg, st_next;
    logic [AW-1:0]        clr_idx_reg;
    logic [acfm_pkg::CMD_W-1:0] cmd_reg;
    logic [CW-1:0]        cidx_reg;
    logic [SW-1:0]        sym_reg;
    logic [FW-1:0]        tgt_reg;
    logic [FW-1:0]        limit_reg;
    logic [FW-1:0]        totals_reg [acfm_pkg::CONTEXTS];
    logic [IW:0]          rd_idx_reg;
    logic                 pend_reg;
    logic [IW-1:0]        dat_idx_reg;
    logic [RW-1:0]        acc_reg;
    acfm_pkg::out_word_t  res_reg;
    logic                 m_valid_reg;
    acfm_pkg::out_word_t  m_data_reg;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [FW-1:0]        ram_wdata, ram_rdata;

    logic                 s_acc, out_free, scan_start;
    logic [FW-1:0]        tot_cur;
    logic [IW-1:0]        sym_idx;
    logic                 sym_ok_in, sym_ok_reg;
    logic                 issue;
    logic [RW-1:0]        run_sum, halve_sum;
    logic [FW-1:0]        half_val, halved;
    logic                 last_idx;
    logic                 enc_bad, enc_hit, dec_hit, dec_miss, hal_end, scan_end;
    logic [FW-1:0]        upd_inc;
    logic [FW:0]          new_tot;
    logic                 need_halve;
    logic [4:0]           scan_flags;
    logic                 done_wait;

    // count ram
    acfm_ram #(
        .WIDTH (FW),
        .DEPTH (acfm_pkg::DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshakes
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // symbol range checks
    assign sym_ok_in  = {1'b0, s_data.symbol_in} < (SW + 1)'(acfm_pkg::SYMBOLS);
    assign sym_ok_reg = {1'b0, sym_reg} < (SW + 1)'(acfm_pkg::SYMBOLS);
    assign sym_idx    = sym_reg[IW-1:0];
    assign tot_cur    = totals_reg[cidx_reg];

    // scan datapath
    assign issue = (st_reg == acfm_pkg::ST_SCAN)
                && (rd_idx_reg < (IW + 1)'(acfm_pkg::SYMBOLS))
                && ((cmd_reg != acfm_pkg::CMD_ENCODE) || (rd_idx_reg <= {1'b0, sym_idx}));
    assign run_sum   = acc_reg + RW'(ram_rdata);
    assign half_val  = ram_rdata >> 1;
    assign halved    = (half_val == '0) ? FW'(1) : half_val;
    assign halve_sum = acc_reg + RW'(halved);
    assign last_idx  = dat_idx_reg == IW'(acfm_pkg::SYMBOLS - 1);

    // scan end conditions
    always_comb begin
        enc_bad  = 1'b0;
        enc_hit  = 1'b0;
        dec_hit  = 1'b0;
        dec_miss = 1'b0;
        hal_end  = 1'b0;
        if (st_reg == acfm_pkg::ST_SCAN) begin
            case (cmd_reg)
                acfm_pkg::CMD_ENCODE: begin
                    enc_bad = !sym_ok_reg;
                    enc_hit = sym_ok_reg && pend_reg && (dat_idx_reg == sym_idx);
                end
                acfm_pkg::CMD_DECODE: begin
                    dec_hit  = pend_reg && (RW'(tgt_reg) < run_sum);
                    dec_miss = pend_reg && !(RW'(tgt_reg) < run_sum) && last_idx;
                end
                acfm_pkg::CMD_UPDATE: begin
                    hal_end = pend_reg && last_idx;
                end
                default: begin
                end
            endcase
        end
    end
    assign scan_end = enc_bad || enc_hit || dec_hit || dec_miss || hal_end;

    // update arithmetic
    assign upd_inc    = ram_rdata + FW'(1);
    assign new_tot    = {1'b0, tot_cur} + (FW + 1)'(1);
    assign need_halve = (new_tot > {1'b0, limit_reg}) || new_tot[FW];

    // ram port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = {cidx_reg, sym_idx};
        ram_raddr = {cidx_reg, sym_idx};
        ram_wdata = upd_inc;
        case (st_reg)
            acfm_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = FW'(1);
            end
            acfm_pkg::ST_UPD_RD: begin
                ram_re = 1'b1;
            end
            acfm_pkg::ST_UPD_WR: begin
                ram_we = 1'b1;
            end
            acfm_pkg::ST_SCAN: begin
                ram_re    = issue;
                ram_raddr = {cidx_reg, rd_idx_reg[IW-1:0]};
                if (cmd_reg == acfm_pkg::CMD_UPDATE && pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = {cidx_reg, dat_idx_reg};
                    ram_wdata = halved;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            acfm_pkg::ST_CLEAR: begin
                if (clr_idx_reg == AW'(acfm_pkg::DEPTH - 1)) st_next = acfm_pkg::ST_IDLE;
            end
            acfm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.command)
                        acfm_pkg::CMD_ENCODE: st_next = acfm_pkg::ST_SCAN;
                        acfm_pkg::CMD_DECODE: st_next = acfm_pkg::ST_SCAN;
                        acfm_pkg::CMD_UPDATE: begin
                            if (sym_ok_in) st_next = acfm_pkg::ST_UPD_RD;
                        end
                        default: st_next = acfm_pkg::ST_IDLE;
                    endcase
                end
            end
            acfm_pkg::ST_UPD_RD: st_next = acfm_pkg::ST_UPD_WR;
            acfm_pkg::ST_UPD_WR: begin
                st_next = need_halve ? acfm_pkg::ST_SCAN : acfm_pkg::ST_IDLE;
            end
            acfm_pkg::ST_SCAN: begin
                if (scan_end) begin
                    st_next = (cmd_reg == acfm_pkg::CMD_UPDATE) ? acfm_pkg::ST_IDLE
                                                                : acfm_pkg::ST_DONE;
                end
            end
            acfm_pkg::ST_DONE: begin
                if (out_free) st_next = acfm_pkg::ST_IDLE;
            end
            default: st_next = acfm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = (st_reg == acfm_pkg::ST_IDLE);
    end

    assign scan_start = (st_next == acfm_pkg::ST_SCAN) && (st_reg != acfm_pkg::ST_SCAN);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= acfm_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            limit_reg   <= acfm_pkg::LIMIT_RESET;
            pend_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < acfm_pkg::CONTEXTS; c++) begin
                totals_reg[c] <= FW'(acfm_pkg::SYMBOLS);
            end
        end else begin
            st_reg <= st_next;
            // clearing pass
            if (st_reg == acfm_pkg::ST_CLEAR) clr_idx_reg <= clr_idx_reg + AW'(1);
            // rescale limit
            if (cfg_valid) limit_reg <= cfg_wdata;
            // read issue tracking
            if (scan_start) begin
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
            end else if (st_reg == acfm_pkg::ST_SCAN) begin
                if (issue) rd_idx_reg <= rd_idx_reg + (IW + 1)'(1);
                pend_reg <= issue;
            end
            // context totals
            if (st_reg == acfm_pkg::ST_UPD_WR && !need_halve) begin
                totals_reg[cidx_reg] <= new_tot[FW-1:0];
            end
            if (hal_end) totals_reg[cidx_reg] <= halve_sum[FW-1:0];
            // output register
            if (st_reg == acfm_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg  <= s_data.command;
            cidx_reg <= s_data.context_id[CW-1:0];
            sym_reg  <= s_data.symbol_in;
            tgt_reg  <= s_data.target;
        end
        dat_idx_reg <= rd_idx_reg[IW-1:0];
        // running sum
        if (scan_start) begin
            acc_reg <= '0;
        end else if (st_reg == acfm_pkg::ST_SCAN && pend_reg) begin
            if (cmd_reg == acfm_pkg::CMD_UPDATE) begin
                acc_reg <= halve_sum;
            end else if (cmd_reg == acfm_pkg::CMD_DECODE || dat_idx_reg < sym_idx) begin
                acc_reg <= run_sum;
            end
        end
        // pending result
        if (enc_bad) begin
            res_reg <= '{symbol_out: sym_reg, cum_low: tot_cur, freq: '0,
                         total: tot_cur, not_found: 1'b1};
        end else if (enc_hit) begin
            res_reg <= '{symbol_out: sym_reg, cum_low: acc_reg[FW-1:0], freq: ram_rdata,
                         total: tot_cur, not_found: 1'b0};
        end else if (dec_hit) begin
            res_reg <= '{symbol_out: SW'(dat_idx_reg), cum_low: acc_reg[FW-1:0],
                         freq: ram_rdata, total: tot_cur, not_found: 1'b0};
        end else if (dec_miss) begin
            res_reg <= '{symbol_out: '0, cum_low: tot_cur, freq: '0,
                         total: tot_cur, not_found: 1'b1};
        end
        if (st_reg == acfm_pkg::ST_DONE && out_free) m_data_reg <= res_reg;
    end

    // check terms
    assign scan_flags = {enc_bad, enc_hit, dec_hit, dec_miss, hal_end};
    assign done_wait  = (st_reg == acfm_pkg::ST_DONE) && !out_free;

    // checks
    `ACFM_ASSERT_NOW(a_one_scan_end, st_reg == acfm_pkg::ST_SCAN, $onehot0(scan_flags))
    `ACFM_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
    `ACFM_ASSERT_NEXT(a_done_holds, done_wait, st_reg == acfm_pkg::ST_DONE && $stable(res_reg))

endmodule
